### hw/rtl/w2h_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package w2h_pkg;

    localparam int VAL_W   = 32;
    localparam int TOTAL_W = 48;
    localparam int BINS_W  = 7;
    localparam int REG_IDX_W = 3;

    // command codes
    typedef enum logic {
        CMD_ACC  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_S_MIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_T_MIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_S_SCALE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_T_SCALE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_S_BINS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_T_BINS  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SRC_SEL = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_USE_V   = 3'd7;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage
`default_nettype wire

### hw/rtl/weighted_2d_histogram_binner.sv
`timescale 1ns / 1ps
`default_nettype none
// Weighted 2-D histogram binner. An item is accepted when start is high and
// busy is low; busy covers the front pipeline and the bin read-modify-write,
// so a new item is taken only once the last one has been written back, and a
// read result appears with done high for one cycle. The receiver cannot stall
// results. After reset a clearing sweep zeroes the bin memory one entry per
// cycle, over the product of both maximum bin counts rounded up to powers of
// two, during which busy is high. Configuration writes are taken only while
// busy is low.
module weighted_2d_histogram_binner #(
    parameter int MAX_S_BINS = 64,
    parameter int MAX_T_BINS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cmd,
    input  wire logic signed [31:0] t_value,
    input  wire logic signed [31:0] s_value,
    input  wire logic signed [31:0] u_vel,
    input  wire logic signed [31:0] v_vel,
    input  wire logic signed [31:0] w_vel,
    input  wire logic [31:0]        weight,
    input  wire logic [5:0]         read_s_bin,
    input  wire logic [5:0]         read_t_bin,
    output logic                    done,
    output logic [47:0]             bin_total,
    output logic [5:0]              out_s_bin,
    output logic [5:0]              out_t_bin,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import w2h_pkg::*;

    localparam int S_IDX_W = (MAX_S_BINS > 1) ? $clog2(MAX_S_BINS) : 1;
    localparam int T_IDX_W = (MAX_T_BINS > 1) ? $clog2(MAX_T_BINS) : 1;
    localparam int DEPTH = (1 << S_IDX_W) * (1 << T_IDX_W);

    logic signed [31:0] s_min_reg, t_min_reg;
    logic [31:0] s_scale_reg, t_scale_reg;
    logic [6:0]  s_bins_reg, t_bins_reg;
    logic [1:0]  src_reg;
    logic        use_v_reg;

    logic q_valid, q_cmd, q_inside, clearing, front_busy, back_busy;
    logic [S_IDX_W-1:0] q_s_idx;
    logic [T_IDX_W-1:0] q_t_idx;
    logic [31:0] q_weight;
    logic [5:0]  q_rs, q_rt;
    logic        accept;

    assign busy      = clearing | front_busy | back_busy;
    assign accept    = start & ~busy;
    assign cfg_ready = ~busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_min_reg   <= '0;
            t_min_reg   <= '0;
            s_scale_reg <= 32'd65536;
            t_scale_reg <= 32'd65536;
            s_bins_reg  <= 7'd64;
            t_bins_reg  <= 7'd64;
            src_reg     <= 2'd0;
            use_v_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_S_MIN:   s_min_reg   <= cfg_data;
                REG_T_MIN:   t_min_reg   <= cfg_data;
                REG_S_SCALE: s_scale_reg <= cfg_data;
                REG_T_SCALE: t_scale_reg <= cfg_data;
                REG_S_BINS:  s_bins_reg  <= cfg_data[6:0];
                REG_T_BINS:  t_bins_reg  <= cfg_data[6:0];
                REG_SRC_SEL: src_reg     <= cfg_data[1:0];
                REG_USE_V:   use_v_reg   <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    w2h_front #(
        .S_IDX_W(S_IDX_W), .T_IDX_W(T_IDX_W),
        .MAX_S_BINS(MAX_S_BINS), .MAX_T_BINS(MAX_T_BINS)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_cmd(cmd),
        .in_t_value(t_value), .in_s_value(s_value), .in_u_vel(u_vel),
        .in_v_vel(v_vel), .in_w_vel(w_vel), .in_weight(weight),
        .in_read_s_bin(read_s_bin), .in_read_t_bin(read_t_bin),
        .s_min(s_min_reg), .t_min(t_min_reg), .s_scale(s_scale_reg),
        .t_scale(t_scale_reg), .s_bins(s_bins_reg), .t_bins(t_bins_reg),
        .source_select(src_reg), .use_v(use_v_reg),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_inside(q_inside),
        .q_s_idx(q_s_idx), .q_t_idx(q_t_idx), .q_weight(q_weight),
        .q_rs(q_rs), .q_rt(q_rt), .front_busy(front_busy)
    );

    w2h_back #(
        .S_IDX_W(S_IDX_W), .T_IDX_W(T_IDX_W), .DEPTH(DEPTH)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
        .q_inside(q_inside), .q_s_idx(q_s_idx), .q_t_idx(q_t_idx),
        .q_weight(q_weight), .q_rs(q_rs), .q_rt(q_rt),
        .clearing(clearing), .back_busy(back_busy), .done(done),
        .bin_total(bin_total), .out_s_bin(out_s_bin), .out_t_bin(out_t_bin)
    );

endmodule
`default_nettype wire

### hw/rtl/w2h_front.sv
`timescale 1ns / 1ps
`default_nettype none
module w2h_front #(
    parameter int S_IDX_W = 6,
    parameter int T_IDX_W = 6,
    parameter int MAX_S_BINS = 64,
    parameter int MAX_T_BINS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_cmd,
    input  wire logic signed [31:0]           in_t_value,
    input  wire logic signed [31:0]           in_s_value,
    input  wire logic signed [31:0]           in_u_vel,
    input  wire logic signed [31:0]           in_v_vel,
    input  wire logic signed [31:0]           in_w_vel,
    input  wire logic [31:0]                  in_weight,
    input  wire logic [5:0]                   in_read_s_bin,
    input  wire logic [5:0]                   in_read_t_bin,
    input  wire logic signed [31:0]           s_min,
    input  wire logic signed [31:0]           t_min,
    input  wire logic [31:0]                  s_scale,
    input  wire logic [31:0]                  t_scale,
    input  wire logic [6:0]                   s_bins,
    input  wire logic [6:0]                   t_bins,
    input  wire logic [1:0]                   source_select,
    input  wire logic                         use_v,
    output logic                              q_valid,
    output logic                              q_cmd,
    output logic                              q_inside,
    output logic [S_IDX_W-1:0]                q_s_idx,
    output logic [T_IDX_W-1:0]                q_t_idx,
    output logic [31:0]                       q_weight,
    output logic [5:0]                        q_rs,
    output logic [5:0]                        q_rt,
    output logic                              front_busy
);
    import w2h_pkg::*;

    // stage 0: squares
    logic        s0_valid_reg;
    logic        s0_cmd_reg;
    logic signed [31:0] s0_t_reg, s0_s_reg;
    logic [63:0] s0_uu_reg, s0_vv_reg, s0_ww_reg;
    logic [31:0] s0_w_reg;
    logic [5:0]  s0_rs_reg, s0_rt_reg;
    // stage 1: axis differences
    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic signed [32:0] s1_ds_reg, s1_dt_reg;
    logic [31:0] s1_w_reg;
    logic [5:0]  s1_rs_reg, s1_rt_reg;
    // stage 2: scaled products
    logic        s2_valid_reg;
    logic        s2_cmd_reg;
    logic        s2_sneg_reg, s2_tneg_reg;
    logic [64:0] s2_ps_reg, s2_pt_reg;
    logic [31:0] s2_w_reg;
    logic [5:0]  s2_rs_reg, s2_rt_reg;

    logic [31:0] mag_u, mag_v, mag_w;
    logic [65:0] ke_sum;
    logic [48:0] ke_shift;
    logic signed [31:0] ke_val, t_sel, s_sel;
    logic [6:0]  s_use, t_use;
    logic [32:0] s_raw, t_raw;
    logic [32:0] s_lim, t_lim;
    logic [32:0] s_fin, t_fin;

    assign mag_u = in_u_vel[31] ? 32'(-in_u_vel) : in_u_vel;
    assign mag_v = in_v_vel[31] ? 32'(-in_v_vel) : in_v_vel;
    assign mag_w = in_w_vel[31] ? 32'(-in_w_vel) : in_w_vel;

    // kinetic energy from registered squares
    always_comb
    begin
        ke_sum = {2'b0, s0_uu_reg} + {2'b0, s0_ww_reg}
               + (use_v ? {2'b0, s0_vv_reg} : 66'd0);
        ke_shift = ke_sum[65:17];
        ke_val = (ke_shift > 49'h7FFFFFFF) ? 32'h7FFFFFFF : ke_shift[31:0];
        t_sel = source_select[0] ? ke_val : s0_t_reg;
        s_sel = source_select[1] ? ke_val : s0_s_reg;
    end

    // bins in use, clamped into 1..max
    always_comb
    begin
        if (s_bins == 7'd0)
            s_use = 7'd1;
        else if (32'(s_bins) > MAX_S_BINS)
            s_use = 7'(MAX_S_BINS);
        else
            s_use = s_bins;
        if (t_bins == 7'd0)
            t_use = 7'd1;
        else if (32'(t_bins) > MAX_T_BINS)
            t_use = 7'(MAX_T_BINS);
        else
            t_use = t_bins;
        s_raw = s2_ps_reg[64:32];
        t_raw = s2_pt_reg[64:32];
        s_lim = 33'(s_use) - 33'd1;
        t_lim = 33'(t_use) - 33'd1;
        s_fin = s2_sneg_reg ? 33'd0 : ((s_raw > s_lim) ? s_lim : s_raw);
        t_fin = s2_tneg_reg ? 33'd0 : ((t_raw > t_lim) ? t_lim : t_raw);
    end

    // pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            q_valid      <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            q_valid      <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_cmd_reg <= in_cmd;
        s0_t_reg   <= in_t_value;
        s0_s_reg   <= in_s_value;
        s0_uu_reg  <= mag_u * mag_u;
        s0_vv_reg  <= mag_v * mag_v;
        s0_ww_reg  <= mag_w * mag_w;
        s0_w_reg   <= in_weight;
        s0_rs_reg  <= in_read_s_bin;
        s0_rt_reg  <= in_read_t_bin;

        s1_cmd_reg <= s0_cmd_reg;
        s1_ds_reg  <= 33'(s_sel) - 33'(s_min);
        s1_dt_reg  <= 33'(t_sel) - 33'(t_min);
        s1_w_reg   <= s0_w_reg;
        s1_rs_reg  <= s0_rs_reg;
        s1_rt_reg  <= s0_rt_reg;

        s2_cmd_reg  <= s1_cmd_reg;
        s2_sneg_reg <= s1_ds_reg[32];
        s2_tneg_reg <= s1_dt_reg[32];
        s2_ps_reg   <= 65'(s1_ds_reg[31:0]) * 65'(s_scale);
        s2_pt_reg   <= 65'(s1_dt_reg[31:0]) * 65'(t_scale);
        s2_w_reg    <= s1_w_reg;
        s2_rs_reg   <= s1_rs_reg;
        s2_rt_reg   <= s1_rt_reg;

        q_cmd    <= s2_cmd_reg;
        q_weight <= s2_w_reg;
        q_rs     <= s2_rs_reg;
        q_rt     <= s2_rt_reg;
        // accumulates always land inside; only reads can point outside the store
        q_inside <= (s2_cmd_reg != CMD_READ)
                 || ((32'(s2_rs_reg) < MAX_S_BINS) && (32'(s2_rt_reg) < MAX_T_BINS));
        if (s2_cmd_reg == CMD_READ)
        begin
            q_s_idx <= S_IDX_W'(s2_rs_reg);
            q_t_idx <= T_IDX_W'(s2_rt_reg);
        end
        else
        begin
            q_s_idx <= S_IDX_W'(s_fin);
            q_t_idx <= T_IDX_W'(t_fin);
        end
    end

    assign front_busy = s0_valid_reg | s1_valid_reg | s2_valid_reg | q_valid;

endmodule
`default_nettype wire

### hw/rtl/w2h_back.sv
`timescale 1ns / 1ps
`default_nettype none
module w2h_back #(
    parameter int S_IDX_W = 6,
    parameter int T_IDX_W = 6,
    parameter int DEPTH = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire logic                 q_cmd,
    input  wire logic                 q_inside,
    input  wire logic [S_IDX_W-1:0]   q_s_idx,
    input  wire logic [T_IDX_W-1:0]   q_t_idx,
    input  wire logic [31:0]          q_weight,
    input  wire logic [5:0]           q_rs,
    input  wire logic [5:0]           q_rt,
    output logic                      clearing,
    output logic                      back_busy,
    output logic                      done,
    output logic [47:0]               bin_total,
    output logic [5:0]                out_s_bin,
    output logic [5:0]                out_t_bin
);
    import w2h_pkg::*;

    localparam int AW = S_IDX_W + T_IDX_W;

    logic [TOTAL_W-1:0] mem [DEPTH];

    // read stage
    logic           r_valid_reg;
    logic           r_cmd_reg;
    logic           r_inside_reg;
    logic [AW-1:0]  r_addr_reg;
    logic [31:0]    r_w_reg;
    logic [5:0]     r_rs_reg, r_rt_reg;
    logic [TOTAL_W-1:0] r_data_reg;
    // clearing sweep
    logic           clr_reg;
    logic [AW-1:0]  clr_addr_reg;

    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] new_val;

    // saturating accumulate
    always_comb
    begin
        sum = {1'b0, r_data_reg} + (TOTAL_W+1)'(r_w_reg);
        new_val = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg  <= 1'b0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            done         <= 1'b0;
        end
        else
        begin
            r_valid_reg <= q_valid;
            done        <= r_valid_reg && (r_cmd_reg == CMD_READ);
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                    clr_reg <= 1'b0;
            end
        end
    end

    // memory read and write-back
    always_ff @(posedge clk)
    begin
        r_cmd_reg    <= q_cmd;
        r_inside_reg <= q_inside;
        r_addr_reg   <= {q_s_idx, q_t_idx};
        r_w_reg      <= q_weight;
        r_rs_reg     <= q_rs;
        r_rt_reg     <= q_rt;
        r_data_reg   <= mem[{q_s_idx, q_t_idx}];
        if (clr_reg)
            mem[clr_addr_reg] <= '0;
        else if (r_valid_reg && r_inside_reg)
            mem[r_addr_reg] <= (r_cmd_reg == CMD_READ) ? '0 : new_val;
        bin_total <= r_inside_reg ? r_data_reg : '0;
        out_s_bin <= r_rs_reg;
        out_t_bin <= r_rt_reg;
    end

    assign clearing  = clr_reg;
    assign back_busy = r_valid_reg;

endmodule
`default_nettype wire

### dv/tb_weighted_2d_histogram_binner.sv
`timescale 1ns / 1ps
module tb_weighted_2d_histogram_binner;
    import w2h_pkg::*;

    localparam int NS = 64;
    localparam int NT = 64;
    localparam int N_RANDOM = 850;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               cmd = 1'b0;
    logic signed [31:0] t_value = '0;
    logic signed [31:0] s_value = '0;
    logic signed [31:0] u_vel = '0;
    logic signed [31:0] v_vel = '0;
    logic signed [31:0] w_vel = '0;
    logic [31:0]        weight = '0;
    logic [5:0]         read_s_bin = '0;
    logic [5:0]         read_t_bin = '0;
    logic               done;
    logic [47:0]        bin_total;
    logic [5:0]         out_s_bin;
    logic [5:0]         out_t_bin;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    typedef struct packed {
        logic [47:0] total;
        logic [5:0]  sb;
        logic [5:0]  tb;
    } bin_read_t;

    // shadow of the block: bin totals and register file
    logic [47:0]        hist_mirror [NS*NT];
    logic signed [31:0] sh_s_min, sh_t_min;
    logic [31:0]        sh_s_scale, sh_t_scale;
    logic [6:0]         sh_s_bins, sh_t_bins;
    logic [1:0]         sh_src_sel;
    logic               sh_use_v;

    bin_read_t pending_reads[$];
    int        n_mismatch = 0;
    bit        idle_free = 1'b0;

    // directed stimulus table
    typedef struct {
        logic        c;
        logic [31:0] tv, sv, uv, vv, wv, wt;
        logic [5:0]  rs, rt;
        bit          fixed;
        logic [47:0] want;
    } stim_row_t;
    stim_row_t dir_rows[$];

    weighted_2d_histogram_binner #(.MAX_S_BINS(NS), .MAX_T_BINS(NT)) uut (.*);

    always #2 clk = ~clk;

    function automatic logic [63:0] mag_sq(logic signed [31:0] x);
        logic [31:0] m;
        m = x[31] ? 32'(-x) : 32'(x);
        return 64'(m) * 64'(m);
    endfunction

    function automatic logic signed [32:0] kinetic_q16(logic signed [31:0] u,
        logic signed [31:0] v, logic signed [31:0] w);
        logic [65:0] sum;
        sum = 66'(mag_sq(u)) + 66'(mag_sq(w));
        if (sh_use_v)
            sum += 66'(mag_sq(v));
        sum = sum >> 17;
        if (sum > 66'h7FFF_FFFF)
            sum = 66'h7FFF_FFFF;
        return 33'(sum);
    endfunction

    function automatic int axis_bin(logic signed [32:0] val, logic signed [31:0] lo,
        logic [31:0] scale, logic [6:0] nreg, int maxb);
        logic signed [33:0] d;
        logic [65:0]        prod;
        int                 nb;
        int                 idx;
        nb = (nreg == 0) ? 1 : ((nreg > maxb) ? maxb : int'(nreg));
        d = 34'(val) - 34'(lo);
        if (d < 0)
            return 0;
        prod = 66'(d[32:0]) * 66'(scale);
        prod = prod >> 32;
        idx = (prod > 66'(nb - 1)) ? nb - 1 : int'(prod);
        return idx;
    endfunction

    // update shadow for one command, return 1 with the read result if any
    function automatic bit predict_bin_op(stim_row_t r, output bin_read_t res);
        logic signed [32:0] tv, sv;
        logic [48:0]        sum;
        int                 si, ti, a;
        res = '0;
        if (r.c == CMD_READ) begin
            a = int'(r.rs) * NT + int'(r.rt);
            res.sb = r.rs;
            res.tb = r.rt;
            if (r.rs < NS && r.rt < NT) begin
                res.total = hist_mirror[a];
                hist_mirror[a] = '0;
            end
            return 1'b1;
        end
        tv = sh_src_sel[0] ? kinetic_q16(r.uv, r.vv, r.wv) : 33'(signed'(r.tv));
        sv = sh_src_sel[1] ? kinetic_q16(r.uv, r.vv, r.wv) : 33'(signed'(r.sv));
        si = axis_bin(sv, sh_s_min, sh_s_scale, sh_s_bins, NS);
        ti = axis_bin(tv, sh_t_min, sh_t_scale, sh_t_bins, NT);
        a = si * NT + ti;
        sum = 49'(hist_mirror[a]) + 49'(r.wt);
        hist_mirror[a] = sum[48] ? TOTAL_MAX : sum[47:0];
        return 1'b0;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_S_MIN:   sh_s_min = val;
            REG_T_MIN:   sh_t_min = val;
            REG_S_SCALE: sh_s_scale = val;
            REG_T_SCALE: sh_t_scale = val;
            REG_S_BINS:  sh_s_bins = val[6:0];
            REG_T_BINS:  sh_t_bins = val[6:0];
            REG_SRC_SEL: sh_src_sel = val[1:0];
            REG_USE_V:   sh_use_v = val[0];
            default:     ;
        endcase
        @(posedge clk);
    endtask

    task automatic issue_cmd(stim_row_t r);
        bin_read_t res;
        while (!idle_free && $urandom_range(99) < 9) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= r.c;
        t_value    <= r.tv;
        s_value    <= r.sv;
        u_vel      <= r.uv;
        v_vel      <= r.vv;
        w_vel      <= r.wv;
        weight     <= r.wt;
        read_s_bin <= r.rs;
        read_t_bin <= r.rt;
        do @(posedge clk); while (busy);
        if (predict_bin_op(r, res)) begin
            if (r.fixed)
                res.total = r.want;
            pending_reads.push_back(res);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // random accumulate or read, mostly into a small region of the grid
    function automatic stim_row_t rand_row();
        stim_row_t r;
        r.fixed = 1'b0;
        r.want = '0;
        r.c = ($urandom_range(3) == 0) ? CMD_READ : CMD_ACC;
        r.tv = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20 << 16);
        r.sv = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20 << 16);
        r.uv = ($urandom_range(3) == 0) ? $urandom
             : 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        r.vv = ($urandom_range(3) == 0) ? $urandom
             : 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        r.wv = ($urandom_range(3) == 0) ? $urandom
             : 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        r.wt = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
        r.rs = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(20));
        r.rt = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(20));
        return r;
    endfunction

    function automatic stim_row_t mk(logic c, logic [31:0] tv, logic [31:0] sv,
        logic [31:0] uv, logic [31:0] vv, logic [31:0] wv, logic [31:0] wt,
        logic [5:0] rs, logic [5:0] rt, bit fixed, logic [47:0] want);
        stim_row_t r;
        r.c = c; r.tv = tv; r.sv = sv; r.uv = uv; r.vv = vv; r.wv = wv;
        r.wt = wt; r.rs = rs; r.rt = rt; r.fixed = fixed; r.want = want;
        return r;
    endfunction

    // result checker
    always @(posedge clk) begin
        bin_read_t exp_r;
        if (rst_n && done) begin
            if (pending_reads.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result s=%0d t=%0d total=%h",
                        out_s_bin, out_t_bin, bin_total);
            end else begin
                exp_r = pending_reads.pop_front();
                if (exp_r.total !== bin_total || exp_r.sb !== out_s_bin
                    || exp_r.tb !== out_t_bin) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch exp s=%0d t=%0d total=%h got s=%0d t=%0d total=%h",
                            exp_r.sb, exp_r.tb, exp_r.total,
                            out_s_bin, out_t_bin, bin_total);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int k;
        for (int i = 0; i < NS*NT; i++)
            hist_mirror[i] = '0;
        sh_s_min = 0; sh_t_min = 0;
        sh_s_scale = 32'd65536; sh_t_scale = 32'd65536;
        sh_s_bins = 7'd64; sh_t_bins = 7'd64;
        sh_src_sel = 2'd0; sh_use_v = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset contents, extremes, full-scale weights, special bins
        dir_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd0, 6'd0, 1, 48'd0));
        dir_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd63, 6'd63, 1, 48'd0));
        dir_rows.push_back(mk(CMD_ACC, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0,
            32'hFFFF_FFFF, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd63, 6'd0, 1, 48'hFFFF_FFFF));
        dir_rows.push_back(mk(CMD_ACC, 32'h0003_8000, 32'h0005_0000, 0, 0, 0,
            32'h0001_0000, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd5, 6'd3, 1, 48'h1_0000));
        for (k = 0; k < 4; k++)
            dir_rows.push_back(mk(CMD_ACC, 32'h0000_0000, 32'h0002_0000, 0, 0, 0,
                32'hFFFF_FFFF, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd2, 6'd0, 0, 0));
        foreach (dir_rows[i])
            issue_cmd(dir_rows[i]);
        drain();

        // repeated full-scale weights into one bin
        for (k = 0; k < 12; k++)
            issue_cmd(mk(CMD_ACC, 32'h0001_0000, 32'h0001_0000, 0, 0, 0,
                32'hFFFF_FFFF, 0, 0, 0, 0));
        drain();
        write_reg(REG_S_SCALE, 32'd0);
        write_reg(REG_T_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_S_BINS, 7'd0);
        write_reg(REG_T_BINS, 7'd127);
        issue_cmd(mk(CMD_ACC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 32'd7, 0, 0, 0, 0));
        issue_cmd(mk(CMD_ACC, 32'h0000_0001, 32'h0000_0001, 0, 0, 0, 32'd9, 0, 0, 0, 0));
        issue_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd0, 6'd63, 0, 0));
        issue_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd1, 6'd1, 0, 0));
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_S_MIN, (ph == 5) ? 32'h8000_0000 :
                ((ph == 4) ? 32'h7FFF_FFFF
                           : 32'($signed($urandom_range(4 << 16)) - (2 << 16))));
            write_reg(REG_T_MIN, (ph == 5) ? 32'h7FFF_FFFF : 32'($urandom_range(2 << 16)));
            write_reg(REG_S_SCALE, (ph == 3) ? 32'hFFFF_FFFF : 32'($urandom_range(8 << 16)));
            write_reg(REG_T_SCALE, (ph == 3) ? 32'd0 : 32'($urandom_range(8 << 16)));
            write_reg(REG_S_BINS, (ph == 0) ? 32'd1 : 32'($urandom_range(127)));
            write_reg(REG_T_BINS, (ph == 0) ? 32'd64 : 32'($urandom_range(127)));
            write_reg(REG_SRC_SEL, 32'(ph % 4));
            write_reg(REG_USE_V, 32'(ph % 2));
            idle_free = (ph == 2);
            for (k = 0; k < N_RANDOM / 6; k++)
                issue_cmd(rand_row());
            drain();
        end

        if (n_mismatch == 0 && pending_reads.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
